// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the conversion unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CTS_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// implication checked at every clock edge out of reset
`define CTS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// types, constants and helper functions of the cartesian to spherical unit
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_COORD_BITS = 32;
  localparam int ANG_FRAC       = 16;
  localparam int ANG_W          = 27;
  localparam int DEG_W          = 12;
  localparam int ATAN_W         = 22;
  localparam int QUEUE_DEPTH    = 2;
  localparam int FULL_TURN      = 360;
  localparam int POLAR_MAX      = 180;

  localparam logic signed [25:0]      GAIN_Q24 = 26'sd27628053;
  localparam logic signed [ANG_W-1:0] ONE80    = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] NINETY   = 27'sd5898240;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
  } point_t;

  typedef struct packed {
    logic [15:0] range_len;
    logic [7:0]  polar_deg;
    logic [8:0]  azimuth_deg;
    logic        zero_point;
  } result_t;

  // classified point as it sits in the queue
  typedef struct packed {
    logic [MAX_COORD_BITS-1:0] x;
    logic [MAX_COORD_BITS-1:0] y;
    logic [MAX_COORD_BITS-1:0] z;
    logic                      zero_pt;
    logic                      xy_zero;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic   avail;
    entry_t entry;
  } q_rd_t;

  typedef struct packed {
    logic [7:0] polar_deg;
    logic [8:0] azimuth_deg;
    logic       zero_point;
  } ang_t;

  // atan(2^-i) in degrees, q16
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // q16 degrees to whole degrees, half away from zero
  function automatic logic signed [DEG_W-1:0] round_deg(input logic signed [ANG_W-1:0] q);
    logic [ANG_W-1:0] mag;
    logic [ANG_W-1:0] r;
    mag = q[ANG_W-1] ? ANG_W'(-q) : ANG_W'(q);
    r   = (mag + (ANG_W'(1) << (ANG_FRAC - 1))) >> ANG_FRAC;
    return q[ANG_W-1] ? -signed'(DEG_W'(r)) : signed'(DEG_W'(r));
  endfunction

endpackage

// File: rtl/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front
// takes points in, sign-extends and classifies them, feeds the queue
// ----------------------------------------------------------------------------
module cts_front import cts_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  point_t point_i,
  input  logic   q_full_i,
  output logic   busy_o,
  output q_wr_t  q_wr_o
);

  logic   valid_q, valid_d;
  entry_t ent_q, ent_d;
  logic   accept, push;
  logic [MAX_COORD_BITS-1:0]    xr, yr, zr;
  logic signed [COORD_BITS-1:0] xs, ys, zs;

  // field bits zero-extended, then the low coordinate bits taken as two's complement
  assign xr = MAX_COORD_BITS'($unsigned(point_i.x_coord));
  assign yr = MAX_COORD_BITS'($unsigned(point_i.y_coord));
  assign zr = MAX_COORD_BITS'($unsigned(point_i.z_coord));

  assign xs = signed'(xr[COORD_BITS-1:0]);
  assign ys = signed'(yr[COORD_BITS-1:0]);
  assign zs = signed'(zr[COORD_BITS-1:0]);

  assign push    = valid_q && !q_full_i;
  assign busy_o  = valid_q && q_full_i;
  assign accept  = start_i && !busy_o;
  assign valid_d = accept || (valid_q && !push);

  always_comb begin
    ent_d         = ent_q;
    if (accept) begin
      ent_d.x       = MAX_COORD_BITS'(xs);
      ent_d.y       = MAX_COORD_BITS'(ys);
      ent_d.z       = MAX_COORD_BITS'(zs);
      ent_d.xy_zero = (xs == '0) && (ys == '0);
      ent_d.zero_pt = (xs == '0) && (ys == '0) && (zs == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign q_wr_o.push  = push;
  assign q_wr_o.entry = ent_q;

endmodule

// File: rtl/cts_queue.sv
// ----------------------------------------------------------------------------
// cts_queue
// short fifo between the classifying front and the conversion pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cts_queue import cts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t q_wr_i,
  input  logic  pop_i,
  output logic  full_o,
  output q_rd_t q_rd_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_pop;

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_pop       = pop_i && (count_q != '0);
  assign q_rd_o.avail = (count_q != '0);
  assign q_rd_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (q_wr_i.push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    count_d = count_q + CNT_W'(q_wr_i.push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_wr_i.push) begin
      mem_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

  `CTS_ASSERT_IMPLY(a_no_push_full, clk_i, rst_ni, full_o, !q_wr_i.push, "push into full queue")
  `CTS_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, count_q <= CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

// File: rtl/cts_back.sv
// ----------------------------------------------------------------------------
// cts_back
// pipelined range root and two vectoring cordic passes, one point per cycle
// ----------------------------------------------------------------------------
module cts_back import cts_pkg::*; #(
  parameter int COORD_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_rd_t   q_rd_i,
  output logic    pop_o,
  output logic    valid_o,
  output result_t result_o
);

  localparam int C     = COORD_BITS;
  localparam int S     = CORDIC_STEPS;
  localparam int W     = C + 28;
  localparam int RW    = 2 * C + 2;
  localparam int RNG_W = (C + 1 > 17) ? C + 1 : 17;
  localparam int LAT_A = 2 * S + 3;
  localparam int LAT_R = C + 3;
  localparam int LAT   = (LAT_A > LAT_R) ? LAT_A : LAT_R;
  localparam int PAD_A = LAT - LAT_A;
  localparam int PAD_R = LAT - LAT_R;

  // entry stage
  logic   v0_q;
  entry_t e0_q;
  logic signed [C-1:0] xs, ys, zs;

  assign pop_o = q_rd_i.avail;
  assign xs    = signed'(e0_q.x[C-1:0]);
  assign ys    = signed'(e0_q.y[C-1:0]);
  assign zs    = signed'(e0_q.z[C-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= q_rd_i.avail;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= q_rd_i.entry;
  end

  // pass one: azimuth and gain-scaled rho
  logic signed [W-1:0]     p1_a_q   [S+1];
  logic signed [W-1:0]     p1_b_q   [S+1];
  logic signed [ANG_W-1:0] p1_acc_q [S+1];
  logic signed [C+25:0]    p1_zk_q  [S+1];
  logic                    p1_zp_q  [S+1];
  logic                    p1_xyz_q [S+1];
  logic [S:0]              p1_v_q;
  logic signed [W-1:0]     x_w, y_w;

  assign x_w = W'(xs) <<< 24;
  assign y_w = W'(ys) <<< 24;

  always_ff @(posedge clk_i) begin
    if (xs < 0) begin
      p1_a_q[0]   <= -x_w;
      p1_b_q[0]   <= -y_w;
      p1_acc_q[0] <= (ys >= 0) ? ONE80 : -ONE80;
    end else begin
      p1_a_q[0]   <= x_w;
      p1_b_q[0]   <= y_w;
      p1_acc_q[0] <= '0;
    end
    p1_zk_q[0]  <= (C+26)'(zs) * (C+26)'(GAIN_Q24);
    p1_zp_q[0]  <= e0_q.zero_pt;
    p1_xyz_q[0] <= e0_q.xy_zero;
    for (int i = 0; i < S; i++) begin
      if (!p1_b_q[i][W-1]) begin
        p1_a_q[i+1]   <= p1_a_q[i] + (p1_b_q[i] >>> i);
        p1_b_q[i+1]   <= p1_b_q[i] - (p1_a_q[i] >>> i);
        p1_acc_q[i+1] <= p1_acc_q[i] + signed'(ANG_W'(atan_q16(5'(i))));
      end else begin
        p1_a_q[i+1]   <= p1_a_q[i] - (p1_b_q[i] >>> i);
        p1_b_q[i+1]   <= p1_b_q[i] + (p1_a_q[i] >>> i);
        p1_acc_q[i+1] <= p1_acc_q[i] - signed'(ANG_W'(atan_q16(5'(i))));
      end
      p1_zk_q[i+1]  <= p1_zk_q[i];
      p1_zp_q[i+1]  <= p1_zp_q[i];
      p1_xyz_q[i+1] <= p1_xyz_q[i];
    end
  end

  // pass two: polar angle from (K*z, K*rho)
  logic signed [W-1:0]     p2_a_q   [S+1];
  logic signed [W-1:0]     p2_b_q   [S+1];
  logic signed [ANG_W-1:0] p2_acc_q [S+1];
  logic [8:0]              p2_az_q  [S+1];
  logic                    p2_zp_q  [S+1];
  logic [S:0]              p2_v_q;
  logic signed [DEG_W-1:0] az_r, az_w;
  logic signed [W-1:0]     zk_w;

  assign zk_w = W'(p1_zk_q[S]);

  always_comb begin
    az_r = round_deg(p1_acc_q[S]);
    az_w = az_r;
    if (az_r < 0) begin
      az_w = az_r + DEG_W'(FULL_TURN);
    end else if (az_r >= DEG_W'(FULL_TURN)) begin
      az_w = az_r - DEG_W'(FULL_TURN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (zk_w < 0) begin
      p2_a_q[0]   <= p1_a_q[S];
      p2_b_q[0]   <= -zk_w;
      p2_acc_q[0] <= NINETY;
    end else begin
      p2_a_q[0]   <= zk_w;
      p2_b_q[0]   <= p1_a_q[S];
      p2_acc_q[0] <= '0;
    end
    p2_az_q[0] <= p1_xyz_q[S] ? 9'd0 : az_w[8:0];
    p2_zp_q[0] <= p1_zp_q[S];
    for (int i = 0; i < S; i++) begin
      if (!p2_b_q[i][W-1]) begin
        p2_a_q[i+1]   <= p2_a_q[i] + (p2_b_q[i] >>> i);
        p2_b_q[i+1]   <= p2_b_q[i] - (p2_a_q[i] >>> i);
        p2_acc_q[i+1] <= p2_acc_q[i] + signed'(ANG_W'(atan_q16(5'(i))));
      end else begin
        p2_a_q[i+1]   <= p2_a_q[i] - (p2_b_q[i] >>> i);
        p2_b_q[i+1]   <= p2_b_q[i] + (p2_a_q[i] >>> i);
        p2_acc_q[i+1] <= p2_acc_q[i] - signed'(ANG_W'(atan_q16(5'(i))));
      end
      p2_az_q[i+1] <= p2_az_q[i];
      p2_zp_q[i+1] <= p2_zp_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= '0;
      p2_v_q <= '0;
    end else begin
      p1_v_q <= {p1_v_q[S-1:0], v0_q};
      p2_v_q <= {p2_v_q[S-1:0], p1_v_q[S]};
    end
  end

  // angle finish
  logic                    ang_v_q;
  ang_t                    ang_q;
  logic signed [DEG_W-1:0] pol_r;
  logic [7:0]              pol_c;

  always_comb begin
    pol_r = round_deg(p2_acc_q[S]);
    if (pol_r < 0) begin
      pol_c = 8'd0;
    end else if (pol_r > DEG_W'(POLAR_MAX)) begin
      pol_c = 8'(POLAR_MAX);
    end else begin
      pol_c = pol_r[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_v_q <= 1'b0;
    end else begin
      ang_v_q <= p2_v_q[S];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q.zero_point  <= p2_zp_q[S];
    ang_q.polar_deg   <= p2_zp_q[S] ? 8'd0 : pol_c;
    ang_q.azimuth_deg <= p2_zp_q[S] ? 9'd0 : p2_az_q[S];
  end

  // range: squares, sum, one root bit per stage, rounding
  logic [C-1:0]    ax, ay, az;
  logic [2*C-1:0]  sqx_q, sqy_q, sqz_q;
  logic [RW-1:0]   rt_rem_q  [C+1];
  logic [C-1:0]    rt_root_q [C+1];
  logic [RW-1:0]   trial     [C];
  logic [RNG_W-1:0] rr;
  logic [15:0]     rng_q;

  assign ax = xs[C-1] ? C'(-xs) : C'(xs);
  assign ay = ys[C-1] ? C'(-ys) : C'(ys);
  assign az = zs[C-1] ? C'(-zs) : C'(zs);

  always_comb begin
    for (int j = 0; j < C; j++) begin
      trial[j] = (RW'(rt_root_q[j]) << (C - j)) | (RW'(1) << (2 * (C - 1 - j)));
    end
    rr = RNG_W'(rt_root_q[C]) + RNG_W'(rt_rem_q[C] > RW'(rt_root_q[C]));
  end

  always_ff @(posedge clk_i) begin
    sqx_q        <= (2*C)'(ax) * (2*C)'(ax);
    sqy_q        <= (2*C)'(ay) * (2*C)'(ay);
    sqz_q        <= (2*C)'(az) * (2*C)'(az);
    rt_rem_q[0]  <= RW'(sqx_q) + RW'(sqy_q) + RW'(sqz_q);
    rt_root_q[0] <= '0;
    for (int j = 0; j < C; j++) begin
      if (rt_rem_q[j] >= trial[j]) begin
        rt_rem_q[j+1]  <= rt_rem_q[j] - trial[j];
        rt_root_q[j+1] <= rt_root_q[j] | (C'(1) << (C - 1 - j));
      end else begin
        rt_rem_q[j+1]  <= rt_rem_q[j];
        rt_root_q[j+1] <= rt_root_q[j];
      end
    end
    rng_q <= (rr > RNG_W'(16'hFFFF)) ? 16'hFFFF : rr[15:0];
  end

  // line up the two chains
  logic ang_v_out;
  ang_t ang_out;
  logic [15:0] rng_out;

  if (PAD_A > 0) begin : g_pad_a
    logic [PAD_A-1:0] v_q;
    ang_t             d_q [PAD_A];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= '0;
      end else begin
        v_q[0] <= ang_v_q;
        for (int k = 1; k < PAD_A; k++) v_q[k] <= v_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      d_q[0] <= ang_q;
      for (int k = 1; k < PAD_A; k++) d_q[k] <= d_q[k-1];
    end
    assign ang_v_out = v_q[PAD_A-1];
    assign ang_out   = d_q[PAD_A-1];
  end else begin : g_nopad_a
    assign ang_v_out = ang_v_q;
    assign ang_out   = ang_q;
  end

  if (PAD_R > 0) begin : g_pad_r
    logic [15:0] d_q [PAD_R];
    always_ff @(posedge clk_i) begin
      d_q[0] <= rng_q;
      for (int k = 1; k < PAD_R; k++) d_q[k] <= d_q[k-1];
    end
    assign rng_out = d_q[PAD_R-1];
  end else begin : g_nopad_r
    assign rng_out = rng_q;
  end

  assign valid_o              = ang_v_out;
  assign result_o.range_len   = rng_out;
  assign result_o.polar_deg   = ang_out.polar_deg;
  assign result_o.azimuth_deg = ang_out.azimuth_deg;
  assign result_o.zero_point  = ang_out.zero_point;

endmodule

// File: rtl/cartesian_to_spherical_degrees_unit.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_degrees_unit
// point (x, y, z) to rounded range, polar angle and azimuth in whole degrees
// ----------------------------------------------------------------------------
//   beat     direction  handshake           payload
//   point    in         start / busy        point_i  (x_coord, y_coord, z_coord)
//   result   out        valid_o strobe      result_o (range_len, polar_deg,
//                                                     azimuth_deg, zero_point)
//
// one point per cycle sustained; every stage of the back pipeline advances
// each clock, so busy only rises if the queue fills
// valid_o follows the accepting edge through the front register, the queue, the entry
// stage and the longer of the two cordic passes and the bit-per-stage range root
// reset clears all valid bits and queue pointers; no clearing pass
// the receiver takes each result in the one cycle valid_o is high
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_spherical_degrees_unit import cts_pkg::*; #(
  parameter int COORD_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  point_t  point_i,
  output logic    valid_o,
  output result_t result_o
);

  // front to queue
  q_wr_t q_wr;
  logic  q_full;
  // queue to back
  q_rd_t q_rd;
  logic  q_pop;

  // front: sign-extend the low coordinate bits and flag origin / z-axis
  cts_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .point_i  (point_i),
    .q_full_i (q_full),
    .busy_o   (busy),
    .q_wr_o   (q_wr)
  );

  // queue decouples acceptance from the conversion pipeline
  cts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .pop_i  (q_pop),
    .full_o (q_full),
    .q_rd_o (q_rd)
  );

  // back: range root and both cordic passes, fully pipelined
  cts_back #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_rd_i   (q_rd),
    .pop_o    (q_pop),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // origin reports zero angles and zero range
  `CTS_ASSERT_IMPLY(a_origin_zero, clk_i, rst_ni, valid_o && result_o.zero_point, (result_o.polar_deg == 8'd0) && (result_o.azimuth_deg == 9'd0) && (result_o.range_len == 16'd0), "origin result not zero")
  // angles stay in their ranges
  `CTS_ASSERT_IMPLY(a_angle_range, clk_i, rst_ni, valid_o, (result_o.polar_deg <= 8'd180) && (result_o.azimuth_deg < 9'd360), "angle out of range")

endmodule
